[rtl/core/imu_deframer_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU packet deframer package
// Shared types and constants for the sensor packet deframer.
// ----------------------------------------------------------------------------
package imu_deframer_pkg;

    // Sync sequence "snp" and the checksum contribution of those three bytes.
    localparam logic [7:0]  SYNC_BYTE_0 = 8'h73;
    localparam logic [7:0]  SYNC_BYTE_1 = 8'h6E;
    localparam logic [7:0]  SYNC_BYTE_2 = 8'h70;
    localparam logic [15:0] SYNC_SUM    = 16'h0151;

    // Configuration register defaults after reset.
    localparam logic [7:0] WARMUP_DEFAULT     = 8'd100;
    localparam logic [7:0] GYRO_ADDR_DEFAULT  = 8'h61;
    localparam logic [7:0] ACCEL_ADDR_DEFAULT = 8'h65;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WARMUP     = 2'd0;
    localparam logic [1:0] CFG_GYRO_ADDR  = 2'd1;
    localparam logic [1:0] CFG_ACCEL_ADDR = 2'd2;

    localparam int PAYLOAD_BYTES = 16;
    localparam int WORD_BITS     = 32;
    localparam int RESULT_BITS   = 3 + 8 * WORD_BITS;
    localparam int RESULT_BYTES  = (RESULT_BITS + 7) / 8;

    // Framing phase of the receiver.
    typedef enum logic [2:0] {
        PH_SYNC = 3'd0,
        PH_TYPE = 3'd1,
        PH_ADDR = 3'd2,
        PH_DATA = 3'd3,
        PH_CKHI = 3'd4,
        PH_CKLO = 3'd5
    } phase_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_CHECKSUM_ERROR = 3'd0,
        ST_WARMUP         = 3'd1,
        ST_GYRO_LATCHED   = 3'd2,
        ST_SAMPLE_READY   = 3'd3,
        ST_OTHER_ADDRESS  = 3'd4
    } status_t;

    typedef logic [WORD_BITS-1:0] word_t;

endpackage : imu_deframer_pkg
`default_nettype wire

[rtl/core/imu_packet_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
// The result of a packet is registered when its last checksum byte leaves the input
// register (the input register feeds the result register directly).
// Throughput: one byte per cycle; the input register only holds when a closing
// checksum byte meets a result register that is still full and not being taken.
// Reset clears framing state, the warm-up count, held gyro words and the
// configuration registers to their defaults; the payload store is not cleared.
// ----------------------------------------------------------------------------
// IMU packet deframer
// Finds "snp" sync, checks the 16-bit sum, and emits one result per packet.
// ----------------------------------------------------------------------------
module imu_packet_deframer
    import imu_deframer_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Configuration write port.
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [7:0]                cfg_data,
    // Input stream.
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [7:0]                s_axis_tdata,   // rx_byte[7:0]
    // Result stream.
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // From bit 0 up: status[2:0], gyro_x, gyro_y, gyro_z, gyro_time, accel_x,
    // accel_y, accel_z, accel_time (32 bits each), then zero fill.
    output logic [RESULT_BYTES*8-1:0]      m_axis_tdata
);

    // Configuration registers.
    logic [7:0] warmup_packets_reg;
    logic [7:0] gyro_addr_reg;
    logic [7:0] accel_addr_reg;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       advance;

    // Framing state.
    phase_t     phase_reg, phase_next;
    logic [1:0] sync_progress_reg, sync_progress_next;
    logic [3:0] byte_index_reg, byte_index_next;
    logic [7:0] packet_addr_reg;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [7:0] ck_high_reg;
    logic [7:0] warmup_seen_reg, warmup_seen_next;
    logic [7:0] payload_mem [PAYLOAD_BYTES];
    word_t      gyro_reg [4];
    word_t      gyro_next [4];

    // Result register.
    logic       out_valid_reg;
    status_t    status_reg, status_next;
    word_t      out_gyro_reg [4];
    word_t      out_accel_reg [4];
    word_t      accel_next [4];
    word_t      payload_word [4];

    logic [7:0] sync_expect;
    logic       sync_match;
    logic       closing;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_packets_reg <= WARMUP_DEFAULT;
            gyro_addr_reg      <= GYRO_ADDR_DEFAULT;
            accel_addr_reg     <= ACCEL_ADDR_DEFAULT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WARMUP:     warmup_packets_reg <= cfg_data;
                CFG_GYRO_ADDR:  gyro_addr_reg      <= cfg_data;
                CFG_ACCEL_ADDR: accel_addr_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Handshake: the held word moves on unless it closes a packet while a
    // result is still waiting.
    assign closing       = (phase_reg == PH_CKLO);
    assign advance       = in_valid_reg && (!closing || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Sync comparison against the next expected byte.
    always_comb
    begin
        case (sync_progress_reg)
            2'd0:    sync_expect = SYNC_BYTE_0;
            2'd1:    sync_expect = SYNC_BYTE_1;
            default: sync_expect = SYNC_BYTE_2;
        endcase
    end
    assign sync_match = (in_byte_reg == sync_expect);

    // Next framing phase.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_SYNC:
            begin
                if (sync_match && sync_progress_reg == 2'd2)
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: phase_next = PH_ADDR;
            PH_ADDR: phase_next = PH_DATA;
            PH_DATA:
            begin
                if (byte_index_reg == 4'hF)
                begin
                    phase_next = PH_CKHI;
                end
            end
            PH_CKHI: phase_next = PH_CKLO;
            PH_CKLO: phase_next = PH_SYNC;
            default: phase_next = PH_SYNC;
        endcase
    end

    // Big-endian payload words as they stand in the store.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            payload_word[k] = {payload_mem[4*k], payload_mem[4*k+1],
                               payload_mem[4*k+2], payload_mem[4*k+3]};
        end
    end

    // Framing datapath and packet verdict.
    always_comb
    begin
        sync_progress_next = sync_progress_reg;
        byte_index_next    = byte_index_reg;
        running_sum_next   = running_sum_reg + {8'd0, in_byte_reg};
        warmup_seen_next   = warmup_seen_reg;
        status_next        = ST_OTHER_ADDRESS;
        for (int k = 0; k < 4; k++)
        begin
            gyro_next[k]  = gyro_reg[k];
            accel_next[k] = '0;
        end
        case (phase_reg)
            PH_SYNC:
            begin
                running_sum_next = running_sum_reg;
                if (sync_match)
                begin
                    if (sync_progress_reg == 2'd2)
                    begin
                        sync_progress_next = 2'd0;
                        running_sum_next   = SYNC_SUM;
                    end
                    else
                    begin
                        sync_progress_next = sync_progress_reg + 2'd1;
                    end
                end
                else
                begin
                    sync_progress_next = (in_byte_reg == SYNC_BYTE_0) ? 2'd1 : 2'd0;
                end
            end
            PH_ADDR:
            begin
                byte_index_next = 4'd0;
            end
            PH_DATA:
            begin
                byte_index_next = byte_index_reg + 4'd1;
            end
            PH_CKHI:
            begin
                // The checksum bytes themselves are not part of the sum.
                running_sum_next = running_sum_reg;
            end
            PH_CKLO:
            begin
                sync_progress_next = 2'd0;
                if ({ck_high_reg, in_byte_reg} != running_sum_reg)
                begin
                    status_next = ST_CHECKSUM_ERROR;
                end
                else if (warmup_seen_reg < warmup_packets_reg)
                begin
                    warmup_seen_next = warmup_seen_reg + 8'd1;
                    status_next      = ST_WARMUP;
                end
                else if (packet_addr_reg == gyro_addr_reg)
                begin
                    status_next = ST_GYRO_LATCHED;
                    for (int k = 0; k < 4; k++)
                    begin
                        gyro_next[k] = payload_word[k];
                    end
                end
                else if (packet_addr_reg == accel_addr_reg)
                begin
                    status_next = ST_SAMPLE_READY;
                    for (int k = 0; k < 4; k++)
                    begin
                        accel_next[k] = payload_word[k];
                    end
                end
                else
                begin
                    status_next = ST_OTHER_ADDRESS;
                end
            end
            default: ;
        endcase
    end

    // Framing state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SYNC;
            sync_progress_reg <= 2'd0;
            byte_index_reg    <= 4'd0;
            packet_addr_reg   <= 8'd0;
            running_sum_reg   <= 16'd0;
            ck_high_reg       <= 8'd0;
            warmup_seen_reg   <= 8'd0;
            for (int k = 0; k < 4; k++)
            begin
                gyro_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            sync_progress_reg <= sync_progress_next;
            byte_index_reg    <= byte_index_next;
            running_sum_reg   <= running_sum_next;
            warmup_seen_reg   <= warmup_seen_next;
            if (phase_reg == PH_ADDR)
            begin
                packet_addr_reg <= in_byte_reg;
            end
            if (phase_reg == PH_CKHI)
            begin
                ck_high_reg <= in_byte_reg;
            end
            for (int k = 0; k < 4; k++)
            begin
                gyro_reg[k] <= gyro_next[k];
            end
        end
    end

    // Payload store, written one byte per cycle during the data phase while the input advances.
    always_ff @(posedge clk)
    begin
        if (advance && phase_reg == PH_DATA)
        begin
            payload_mem[byte_index_reg] <= in_byte_reg;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && closing)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance && closing)
        begin
            status_reg <= status_next;
            for (int k = 0; k < 4; k++)
            begin
                out_gyro_reg[k]  <= gyro_next[k];
                out_accel_reg[k] <= accel_next[k];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(RESULT_BYTES*8-RESULT_BITS){1'b0}},
                            out_accel_reg[3], out_accel_reg[2],
                            out_accel_reg[1], out_accel_reg[0],
                            out_gyro_reg[3], out_gyro_reg[2],
                            out_gyro_reg[1], out_gyro_reg[0],
                            status_reg};

    // Accel words are only carried by a sample-ready result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_SAMPLE_READY) |->
        (out_accel_reg[0] == '0 && out_accel_reg[1] == '0 &&
         out_accel_reg[2] == '0 && out_accel_reg[3] == '0))
        else $error("accel words set on a result that is not a sample");

    // The warm-up count only moves together with a warm-up discard result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (warmup_seen_reg != $past(warmup_seen_reg)) |->
        (out_valid_reg && status_reg == ST_WARMUP))
        else $error("warm-up count changed without a discard result");

    // The payload index runs only inside the data phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_index_reg != 4'd0) |-> (phase_reg == PH_DATA))
        else $error("payload index nonzero outside the data phase");

    // The input side stalls only on a closing word behind a full result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && closing && out_valid_reg))
        else $error("input stalled without a pending result");

endmodule : imu_packet_deframer
`default_nettype wire

[verif/imu_packet_deframer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU packet deframer regression bench
// Streams framed sensor packets, line noise and broken frames into the
// deframer, tracks the framing state alongside it to predict one report per
// finished packet, and compares every report word with that prediction.
// ----------------------------------------------------------------------------
module imu_packet_deframer_test;
    import imu_deframer_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 10;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int RANDOM_BYTES   = 600;
    localparam int MIN_REPORTS    = 40;
    localparam int PHASE_BYTES    = 150;
    localparam int FRAME_BYTES    = 23;

    // Register index that maps to no register; writes to it must be dropped.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum {PAY_RANDOM, PAY_ZERO, PAY_ONES} fill_t;
    typedef enum {SUM_GOOD, SUM_BAD_HIGH, SUM_BAD_LOW} sum_fault_t;

    typedef struct packed {
        status_t         status;
        word_t [3:0]     gyro;
        word_t [3:0]     accel;
    } imu_report_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [1:0]                 cfg_index = CFG_WARMUP;
    logic [7:0]                 cfg_data = 8'd0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [7:0]                 s_axis_tdata = 8'd0;   // rx_byte[7:0]
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // From bit 0 up: status[2:0], gyro x/y/z/time, accel x/y/z/time, zero fill.
    logic [RESULT_BYTES*8-1:0]  m_axis_tdata;

    imu_packet_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Stimulus and expectation stores.
    logic [7:0]     pending_bytes [$];
    imu_report_t    expected_reports [$];
    int             failures = 0;
    int             reports_predicted = 0;
    int             framed_bytes = 0;
    int             byte_gap = 0;
    int             result_stall = 0;
    int             quiet_cycles = 0;
    bit             calm_phase = 1'b0;
    string          axis_name [4] = '{"x", "y", "z", "time"};

    // Configuration as the deframer should currently hold it.
    logic [7:0]     set_warmup = WARMUP_DEFAULT;
    logic [7:0]     set_gyro_addr = GYRO_ADDR_DEFAULT;
    logic [7:0]     set_accel_addr = ACCEL_ADDR_DEFAULT;

    // Framing state tracked alongside the deframer.
    phase_t         rx_phase = PH_SYNC;
    int unsigned    sync_matched = 0;
    int unsigned    payload_pos = 0;
    logic [7:0]     frame_addr = 8'd0;
    logic [15:0]    frame_sum = 16'd0;
    logic [7:0]     frame_payload [16];
    logic [7:0]     sum_high = 8'd0;
    logic [7:0]     warm_count = 8'd0;
    word_t          held_gyro [4] = '{default: '0};

    always #CLK_HALF clk = ~clk;

    // Advances the tracked framing state by one received byte and queues the
    // report of a packet when its closing checksum byte arrives.
    task automatic track_frame_byte(input logic [7:0] b);
        logic [7:0]  sync_want;
        imu_report_t rep;
        case (rx_phase)
            PH_SYNC:
            begin
                case (sync_matched)
                    0:       sync_want = SYNC_BYTE_0;
                    1:       sync_want = SYNC_BYTE_1;
                    default: sync_want = SYNC_BYTE_2;
                endcase
                if (b == sync_want)
                begin
                    if (sync_matched == 2)
                    begin
                        sync_matched = 0;
                        frame_sum = SYNC_SUM;
                        rx_phase = PH_TYPE;
                    end
                    else
                        sync_matched = sync_matched + 1;
                end
                else
                    // A stray 's' can itself open a new sync match.
                    sync_matched = (b == SYNC_BYTE_0) ? 1 : 0;
            end
            PH_TYPE:
            begin
                frame_sum = frame_sum + b;
                rx_phase = PH_ADDR;
            end
            PH_ADDR:
            begin
                frame_addr = b;
                frame_sum = frame_sum + b;
                payload_pos = 0;
                rx_phase = PH_DATA;
            end
            PH_DATA:
            begin
                frame_payload[payload_pos] = b;
                frame_sum = frame_sum + b;
                if (payload_pos == 15)
                begin
                    payload_pos = 0;
                    rx_phase = PH_CKHI;
                end
                else
                    payload_pos = payload_pos + 1;
            end
            PH_CKHI:
            begin
                sum_high = b;
                rx_phase = PH_CKLO;
            end
            PH_CKLO:
            begin
                rx_phase = PH_SYNC;
                sync_matched = 0;
                rep.accel = '0;
                if ({sum_high, b} != frame_sum)
                    rep.status = ST_CHECKSUM_ERROR;
                else if (warm_count < set_warmup)
                begin
                    warm_count = warm_count + 8'd1;
                    rep.status = ST_WARMUP;
                end
                else if (frame_addr == set_gyro_addr)
                begin
                    // Gyro wins when both registers name the same address.
                    for (int k = 0; k < 4; k++)
                        held_gyro[k] = {frame_payload[4*k], frame_payload[4*k+1],
                                        frame_payload[4*k+2], frame_payload[4*k+3]};
                    rep.status = ST_GYRO_LATCHED;
                end
                else if (frame_addr == set_accel_addr)
                begin
                    for (int k = 0; k < 4; k++)
                        rep.accel[k] = {frame_payload[4*k], frame_payload[4*k+1],
                                        frame_payload[4*k+2], frame_payload[4*k+3]};
                    rep.status = ST_SAMPLE_READY;
                end
                else
                    rep.status = ST_OTHER_ADDRESS;
                for (int k = 0; k < 4; k++)
                    rep.gyro[k] = held_gyro[k];
                expected_reports.push_back(rep);
                reports_predicted++;
            end
            default:
            begin
                rx_phase = PH_SYNC;
                sync_matched = 0;
            end
        endcase
    endtask

    // Compares one result word with the oldest expected report.
    task automatic check_report(input logic [RESULT_BYTES*8-1:0] data);
        imu_report_t want;
        word_t       got;
        if (expected_reports.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, data);
            failures++;
        end
        else
        begin
            want = expected_reports.pop_front();
            if (data[2:0] !== want.status)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, data[2:0]);
                failures++;
            end
            for (int k = 0; k < 4; k++)
            begin
                got = data[3 + WORD_BITS*k +: WORD_BITS];
                if (got !== want.gyro[k])
                begin
                    $display("%0t: gyro %s mismatch, expected %h, actual %h",
                             $time, axis_name[k], want.gyro[k], got);
                    failures++;
                end
                got = data[3 + WORD_BITS*(4+k) +: WORD_BITS];
                if (got !== want.accel[k])
                begin
                    $display("%0t: accel %s mismatch, expected %h, actual %h",
                             $time, axis_name[k], want.accel[k], got);
                    failures++;
                end
            end
        end
    endtask

    // Byte driver: presents queued bytes with a random gap after each one, except in a calm phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'd0;
            byte_gap <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                track_frame_byte(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (byte_gap != 0)
                begin
                    byte_gap <= byte_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    s_axis_tdata <= pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    byte_gap <= calm_phase ? 0 : $urandom_range(0, 4);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted word and, outside a calm phase, holds
    // off for a random stall once the next result is offered.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            result_stall <= 2;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            check_report(m_axis_tdata);
            if (calm_phase)
            begin
                result_stall <= 0;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                result_stall <= $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end
        end
        else if (m_axis_tvalid && result_stall != 0)
        begin
            result_stall <= result_stall - 1;
            m_axis_tready <= (result_stall == 1);
        end
        else
            m_axis_tready <= (result_stall == 0);
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("imu_packet_deframer regression: fail");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
    endtask

    // Queues one complete frame; the checksum can be spoiled in either byte.
    task automatic queue_packet(input logic [7:0] addr, input fill_t fill,
                                input sum_fault_t fault);
        logic [15:0] sum;
        logic [7:0]  kind;
        logic [7:0]  data;
        sum = SYNC_SUM;
        push_byte(SYNC_BYTE_0);
        push_byte(SYNC_BYTE_1);
        push_byte(SYNC_BYTE_2);
        kind = 8'($urandom_range(0, 255));
        push_byte(kind);
        push_byte(addr);
        sum = sum + kind + addr;
        for (int k = 0; k < 16; k++)
        begin
            case (fill)
                PAY_ZERO: data = 8'h00;
                PAY_ONES: data = 8'hFF;
                default:  data = 8'($urandom_range(0, 255));
            endcase
            push_byte(data);
            sum = sum + data;
        end
        if (fault == SUM_BAD_HIGH)
            sum[15:8] = sum[15:8] ^ 8'($urandom_range(1, 255));
        else if (fault == SUM_BAD_LOW)
            sum[7:0] = sum[7:0] ^ 8'($urandom_range(1, 255));
        push_byte(sum[15:8]);
        push_byte(sum[7:0]);
        framed_bytes += FRAME_BYTES;
    endtask

    // Line noise, biased toward sync bytes so partial matches are common.
    task automatic queue_noise(input int count);
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 5))
                0:       push_byte(SYNC_BYTE_0);
                1:       push_byte(SYNC_BYTE_1);
                2:       push_byte(SYNC_BYTE_2);
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // A sync followed by a frame body cut at a random point, possibly complete; a cut-off body swallows the next frame.
    task automatic queue_broken_packet();
        int cut;
        cut = $urandom_range(0, 20);
        push_byte(SYNC_BYTE_0);
        push_byte(SYNC_BYTE_1);
        push_byte(SYNC_BYTE_2);
        for (int k = 0; k < cut; k++)
            push_byte(8'($urandom_range(0, 255)));
        framed_bytes += cut + 3;
    endtask

    function automatic logic [7:0] pick_address();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return set_gyro_addr;
            4, 5, 6, 7: return set_accel_addr;
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_register(input logic [1:0] index, input logic [7:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            CFG_WARMUP:     set_warmup = value;
            CFG_GYRO_ADDR:  set_gyro_addr = value;
            CFG_ACCEL_ADDR: set_accel_addr = value;
            default:        ;
        endcase
    endtask

    task automatic configure(input logic [7:0] warm, input logic [7:0] gyro,
                             input logic [7:0] accel);
        write_register(CFG_WARMUP, warm);
        write_register(CFG_GYRO_ADDR, gyro);
        write_register(CFG_ACCEL_ADDR, accel);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every byte is taken and every report has come back.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int          phase_start;
        int          random_bytes;
        int          pick;
        logic [7:0]  warm;
        logic [7:0]  gyro;
        logic [7:0]  accel;

        random_bytes = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: valid frames only count toward the warm-up. The
        // leading bytes exercise the sliding sync match on a repeated 's'
        // and on a restart after "sn".
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(SYNC_BYTE_0);
        queue_packet(GYRO_ADDR_DEFAULT, PAY_RANDOM, SUM_GOOD);
        push_byte(SYNC_BYTE_0);
        push_byte(SYNC_BYTE_1);
        queue_packet(ACCEL_ADDR_DEFAULT, PAY_RANDOM, SUM_GOOD);
        queue_packet(GYRO_ADDR_DEFAULT, PAY_RANDOM, SUM_BAD_HIGH);
        wait_for_drain();

        // Warm-up lowered below the count ends it; extreme addresses.
        write_register(CFG_UNUSED, 8'hFF);
        configure(8'd0, 8'h00, 8'hFF);
        queue_packet(8'h00, PAY_ONES, SUM_GOOD);
        queue_packet(8'hFF, PAY_ZERO, SUM_GOOD);
        queue_packet(8'hFF, PAY_RANDOM, SUM_GOOD);
        queue_packet(8'h80, PAY_RANDOM, SUM_GOOD);
        queue_packet(8'h00, PAY_RANDOM, SUM_BAD_LOW);
        wait_for_drain();

        // Largest warm-up, then equal gyro and accel addresses.
        configure(8'd255, 8'h42, 8'h42);
        queue_packet(8'h42, PAY_RANDOM, SUM_GOOD);
        wait_for_drain();
        configure(8'd4, 8'h42, 8'h42);
        queue_packet(8'h42, PAY_RANDOM, SUM_GOOD);
        queue_packet(8'h42, PAY_RANDOM, SUM_GOOD);
        queue_packet(8'h43, PAY_RANDOM, SUM_GOOD);
        wait_for_drain();

        // Random phases, each with its own register settings.
        while (random_bytes < RANDOM_BYTES || reports_predicted < MIN_REPORTS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                warm = 8'd0;
            else if (pick < 9)
                warm = (warm_count > 8'd251) ? 8'd255 : warm_count + 8'($urandom_range(1, 3));
            else
                warm = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                gyro = GYRO_ADDR_DEFAULT;
                accel = ACCEL_ADDR_DEFAULT;
            end
            else
            begin
                gyro = 8'($urandom_range(0, 255));
                accel = (pick < 5) ? gyro : 8'($urandom_range(0, 255));
            end
            configure(warm, gyro, accel);
            calm_phase = ($urandom_range(0, 3) == 0);

            phase_start = framed_bytes;
            while (framed_bytes - phase_start < PHASE_BYTES)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    queue_packet(pick_address(),
                                 ($urandom_range(0, 9) == 0) ? PAY_ONES : PAY_RANDOM,
                                 ($urandom_range(0, 6) == 0) ? SUM_BAD_LOW : SUM_GOOD);
                else if (pick < 16)
                    queue_noise($urandom_range(1, 6));
                else if (pick < 18)
                    queue_packet(pick_address(), PAY_RANDOM, SUM_BAD_HIGH);
                else
                    queue_broken_packet();
            end
            random_bytes += framed_bytes - phase_start;
            wait_for_drain();
            calm_phase = 1'b0;
        end

        wait_for_drain();
        repeat (END_CYCLES) @(posedge clk);
        if (failures == 0 && expected_reports.size() == 0)
            $display("imu_packet_deframer regression: pass");
        else
            $display("imu_packet_deframer regression: fail");
        $finish;
    end

endmodule
